// ===== hw/rtl/trrb_pkg.sv =====
// shared types and constants for the transfer receive reorder buffer
// no dependencies; imported by every module of the block

package trrb_pkg;

    localparam int WINDOW_DEFAULT   = 32;
    localparam int TAG_BITS_DEFAULT = 16;
    localparam int MAX_DRAIN        = 32;
    localparam int DRAIN_CNT_W      = $clog2(MAX_DRAIN);

    localparam int ID_W  = 64;
    localparam int SEQ_W = 64;
    localparam int VER_W = 64;
    localparam int TAG_W = 16;

    localparam int CFG_DATA_W = 64;
    localparam int CFG_ADDR_W = 4;

    typedef enum logic [1:0] {
        CMD_DATA      = 2'd0,
        CMD_HS_ACK    = 2'd1,
        CMD_WIPE_DONE = 2'd2
    } cmd_t;

    typedef enum logic [2:0] {
        KIND_REACK    = 3'd0,
        KIND_PUT      = 3'd1,
        KIND_DELETE   = 3'd2,
        KIND_WIPE_REQ = 3'd3,
        KIND_WIPED    = 3'd4
    } kind_t;

    typedef enum logic [0:0] {
        REG_EXPECTED_SOURCE = 1'b0,
        REG_TRANSFER_NUMBER = 1'b1
    } cfg_reg_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_CHECK,
        ST_DECIDE,
        ST_DRAIN,
        ST_SEND_REACK,
        ST_SEND_WIPE_REQ,
        ST_SEND_WIPED
    } state_t;

    typedef struct packed {
        logic [1:0]       cmd;
        logic [ID_W-1:0]  src_id;
        logic [ID_W-1:0]  xfer_id;
        logic [SEQ_W-1:0] seq_no;
        logic             put_flag;
        logic [VER_W-1:0] obj_version;
        logic [TAG_W-1:0] payload_tag;
        logic             wipe_flag;
    } item_word_t;

    typedef struct packed {
        kind_t            kind;
        logic [SEQ_W-1:0] out_seq;
        logic [VER_W-1:0] out_version;
        logic [TAG_W-1:0] out_tag;
        logic             last;
    } result_word_t;

    typedef struct packed {
        logic  latch_item;
        logic  store_slot;
        logic  set_handshake;
        logic  set_wipe_done;
        logic  load_single;
        kind_t single_kind;
        logic  deliver;
        logic  deliver_last;
    } ctrl_cmd_t;

    typedef struct packed {
        logic [1:0] cmd;
        logic       xfer_match;
        logic       src_match;
        logic       stale;
        logic       in_window;
        logic       duplicate;
        logic       handshake_done;
        logic       wipe_pending;
        logic       any_valid;
        logic       head_valid;
        logic       next_valid;
        logic       out_free;
    } dp_status_t;

endpackage

// ===== hw/rtl/trrb_datapath.sv =====
// datapath: item latch, sequence window, slot store, handshake flags, result register
// depends on trrb_pkg; driven by trrb_ctrl

module trrb_datapath #(
    parameter int WINDOW   = trrb_pkg::WINDOW_DEFAULT,
    parameter int TAG_BITS = trrb_pkg::TAG_BITS_DEFAULT
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  trrb_pkg::item_word_t         item,
    input  logic [trrb_pkg::ID_W-1:0]    cfg_source,
    input  logic [trrb_pkg::ID_W-1:0]    cfg_transfer,
    input  trrb_pkg::ctrl_cmd_t          cmd,
    output trrb_pkg::dp_status_t         status,
    output logic                         result_valid,
    input  logic                         result_stall,
    output trrb_pkg::result_word_t       result
);
    import trrb_pkg::*;

    localparam int IDX_W  = $clog2(WINDOW);
    localparam int INFO_W = TAG_BITS + 1;

    item_word_t        item_reg;
    logic [SEQ_W-1:0]  ne_reg, ne_next;
    logic [IDX_W-1:0]  head_reg, head_next;
    logic [WINDOW-1:0] valid_reg, valid_next;
    logic              hs_done_reg, hs_done_next;
    logic              wipe_need_reg, wipe_need_next;
    logic              wipe_fin_reg, wipe_fin_next;
    logic              result_valid_reg, result_valid_next;
    result_word_t      result_reg, result_next;

    logic [VER_W-1:0]  ver_mem [WINDOW];
    logic [INFO_W-1:0] info_mem [WINDOW];
    logic [VER_W-1:0]  rd_ver_reg;
    logic [INFO_W-1:0] rd_info_reg;

    logic [SEQ_W-1:0]  diff;
    logic [IDX_W:0]    slot_sum;
    logic [IDX_W-1:0]  slot_idx;
    logic [IDX_W-1:0]  head_adv;
    logic [IDX_W-1:0]  rd_addr;
    logic              rd_put;

    // slot of an in-window item, relative to the head slot
    always_comb
    begin
        diff     = item_reg.seq_no - ne_reg;
        slot_sum = {1'b0, head_reg} + {1'b0, diff[IDX_W-1:0]};
        if (slot_sum >= (IDX_W+1)'(WINDOW))
        begin
            slot_sum = slot_sum - (IDX_W+1)'(WINDOW);
        end
        slot_idx = slot_sum[IDX_W-1:0];
    end

    // head follows next_expected modulo the window, including the 2^64 wrap
    always_comb
    begin
        priority if (ne_reg == '1)
        begin
            head_adv = '0;
        end
        else if (head_reg == IDX_W'(WINDOW - 1))
        begin
            head_adv = '0;
        end
        else
        begin
            head_adv = head_reg + IDX_W'(1);
        end
    end

    assign rd_addr = cmd.deliver ? head_adv : head_reg;
    assign rd_put  = rd_info_reg[TAG_BITS];

    always_comb
    begin
        status.cmd            = item_reg.cmd;
        status.xfer_match     = (item_reg.xfer_id == cfg_transfer);
        status.src_match      = (item_reg.src_id == cfg_source);
        status.stale          = (item_reg.seq_no < ne_reg);
        status.in_window      = (diff < SEQ_W'(WINDOW));
        status.duplicate      = valid_reg[slot_idx];
        status.handshake_done = hs_done_reg;
        status.wipe_pending   = wipe_need_reg & ~wipe_fin_reg;
        status.any_valid      = |valid_reg;
        status.head_valid     = valid_reg[head_reg];
        status.next_valid     = valid_reg[head_adv];
        status.out_free       = ~result_valid_reg | ~result_stall;
    end

    always_comb
    begin
        ne_next        = ne_reg;
        head_next      = head_reg;
        valid_next     = valid_reg;
        hs_done_next   = hs_done_reg;
        wipe_need_next = wipe_need_reg;
        wipe_fin_next  = wipe_fin_reg;
        if (cmd.store_slot)
        begin
            valid_next[slot_idx] = 1'b1;
        end
        if (cmd.set_handshake && !hs_done_reg)
        begin
            hs_done_next   = 1'b1;
            wipe_need_next = item_reg.wipe_flag;
        end
        if (cmd.set_wipe_done)
        begin
            wipe_fin_next = 1'b1;
        end
        if (cmd.deliver)
        begin
            valid_next[head_reg] = 1'b0;
            ne_next              = ne_reg + SEQ_W'(1);
            head_next            = head_adv;
        end
    end

    always_comb
    begin
        result_valid_next = result_valid_reg & result_stall;
        result_next       = result_reg;
        priority if (cmd.load_single)
        begin
            result_valid_next       = 1'b1;
            result_next.kind        = cmd.single_kind;
            result_next.out_seq     = (cmd.single_kind == KIND_REACK) ? item_reg.seq_no : '0;
            result_next.out_version = '0;
            result_next.out_tag     = '0;
            result_next.last        = 1'b1;
        end
        else if (cmd.deliver)
        begin
            result_valid_next       = 1'b1;
            result_next.kind        = rd_put ? KIND_PUT : KIND_DELETE;
            result_next.out_seq     = ne_reg;
            result_next.out_version = rd_put ? rd_ver_reg : '0;
            result_next.out_tag     = TAG_W'(rd_info_reg[TAG_BITS-1:0]);
            result_next.last        = cmd.deliver_last;
        end
        else
        begin
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ne_reg           <= '0;
            head_reg         <= '0;
            valid_reg        <= '0;
            hs_done_reg      <= 1'b0;
            wipe_need_reg    <= 1'b0;
            wipe_fin_reg     <= 1'b0;
            result_valid_reg <= 1'b0;
        end
        else
        begin
            ne_reg           <= ne_next;
            head_reg         <= head_next;
            valid_reg        <= valid_next;
            hs_done_reg      <= hs_done_next;
            wipe_need_reg    <= wipe_need_next;
            wipe_fin_reg     <= wipe_fin_next;
            result_valid_reg <= result_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        result_reg <= result_next;
        if (cmd.latch_item)
        begin
            item_reg <= item;
        end
    end

    // slot store
    always_ff @(posedge clk)
    begin
        if (cmd.store_slot)
        begin
            ver_mem[slot_idx]  <= item_reg.obj_version;
            info_mem[slot_idx] <= {item_reg.put_flag, TAG_BITS'(item_reg.payload_tag)};
        end
        rd_ver_reg  <= ver_mem[rd_addr];
        rd_info_reg <= info_mem[rd_addr];
    end

    assign result_valid = result_valid_reg;
    assign result       = result_reg;

endmodule

// ===== hw/rtl/trrb_ctrl.sv =====
// controller: sequences one word through check, store and in-order drain
// depends on trrb_pkg; commands trrb_datapath

module trrb_ctrl (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 item_valid,
    output logic                 item_stall,
    input  trrb_pkg::dp_status_t status,
    output trrb_pkg::ctrl_cmd_t  cmd
);
    import trrb_pkg::*;

    state_t                 state_reg, state_next;
    logic [DRAIN_CNT_W-1:0] count_reg, count_next;
    logic                   drain_last;

    assign drain_last = (count_reg == DRAIN_CNT_W'(MAX_DRAIN - 1)) | ~status.next_valid;

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (item_valid)
                begin
                    state_next = ST_CHECK;
                end
            end
            ST_CHECK:
            begin
                state_next = ST_IDLE;
                if (status.xfer_match)
                begin
                    unique case (status.cmd)
                        CMD_DATA:
                        begin
                            priority if (!status.src_match)
                            begin
                                state_next = ST_IDLE;
                            end
                            else if (status.stale)
                            begin
                                state_next = ST_SEND_REACK;
                            end
                            else if (status.in_window && !status.duplicate)
                            begin
                                state_next = ST_DECIDE;
                            end
                            else
                            begin
                                state_next = ST_IDLE;
                            end
                        end
                        CMD_HS_ACK:
                        begin
                            if (status.src_match)
                            begin
                                state_next = ST_DECIDE;
                            end
                        end
                        CMD_WIPE_DONE:
                        begin
                            state_next = ST_DECIDE;
                        end
                        default:
                        begin
                            state_next = ST_IDLE;
                        end
                    endcase
                end
            end
            ST_DECIDE:
            begin
                priority if (!status.handshake_done)
                begin
                    state_next = ST_IDLE;
                end
                else if (status.wipe_pending)
                begin
                    state_next = ST_SEND_WIPE_REQ;
                end
                else if (!status.any_valid)
                begin
                    state_next = ST_SEND_WIPED;
                end
                else if (status.head_valid)
                begin
                    state_next = ST_DRAIN;
                end
                else
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_DRAIN:
            begin
                if (status.out_free && drain_last)
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_SEND_REACK, ST_SEND_WIPE_REQ, ST_SEND_WIPED:
            begin
                if (status.out_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        item_stall        = (state_reg != ST_IDLE);
        cmd               = '0;
        cmd.single_kind   = KIND_REACK;
        count_next        = count_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                cmd.latch_item = item_valid;
            end
            ST_CHECK:
            begin
                if (status.xfer_match)
                begin
                    unique case (status.cmd)
                        CMD_DATA:
                        begin
                            cmd.store_slot = status.src_match & ~status.stale
                                           & status.in_window & ~status.duplicate;
                        end
                        CMD_HS_ACK:
                        begin
                            cmd.set_handshake = status.src_match;
                        end
                        CMD_WIPE_DONE:
                        begin
                            cmd.set_wipe_done = 1'b1;
                        end
                        default:
                        begin
                        end
                    endcase
                end
            end
            ST_DECIDE:
            begin
                count_next = '0;
            end
            ST_DRAIN:
            begin
                if (status.out_free)
                begin
                    cmd.deliver      = 1'b1;
                    cmd.deliver_last = drain_last;
                    count_next       = count_reg + DRAIN_CNT_W'(1);
                end
            end
            ST_SEND_REACK:
            begin
                cmd.load_single = status.out_free;
                cmd.single_kind = KIND_REACK;
            end
            ST_SEND_WIPE_REQ:
            begin
                cmd.load_single = status.out_free;
                cmd.single_kind = KIND_WIPE_REQ;
            end
            ST_SEND_WIPED:
            begin
                cmd.load_single = status.out_free;
                cmd.single_kind = KIND_WIPED;
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            count_reg <= '0;
        end
        else
        begin
            state_reg <= state_next;
            count_reg <= count_next;
        end
    end

endmodule

// ===== hw/rtl/transfer_receive_reorder_buffer_top.sv =====
// path: a re-ack word goes through the check and send-reack states, a dropped one through
//   check only, the rest through check and decide and then drain, a send state or idle
// the input stalls until idle; the drain emits one word a cycle while the result
//   is not stalled, via the slot store's registered read port, at most 32 per input word
// reset: control, sequence counter, slot valid bits and flags clear at once;
//   slot contents are not cleared and need no clearing pass

module transfer_receive_reorder_buffer_top #(
    parameter int WINDOW   = trrb_pkg::WINDOW_DEFAULT,
    parameter int TAG_BITS = trrb_pkg::TAG_BITS_DEFAULT
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              item_valid,
    output logic                              item_stall,
    input  trrb_pkg::item_word_t              item,
    output logic                              result_valid,
    input  logic                              result_stall,
    output trrb_pkg::result_word_t            result,
    input  logic                              psel,
    input  logic                              penable,
    input  logic                              pwrite,
    input  logic [trrb_pkg::CFG_ADDR_W-1:0]   paddr,
    input  logic [trrb_pkg::CFG_DATA_W-1:0]   pwdata,
    output logic [trrb_pkg::CFG_DATA_W-1:0]   prdata,
    output logic                              pready
);
    import trrb_pkg::*;

    logic [ID_W-1:0] src_cfg_reg;
    logic [ID_W-1:0] xfer_cfg_reg;
    logic            cfg_write;
    cfg_reg_t        cfg_sel;
    ctrl_cmd_t       cmd;
    dp_status_t      status;

    // registers sit at 8-byte steps
    assign cfg_sel   = cfg_reg_t'(paddr[3]);
    assign pready    = 1'b1;
    assign cfg_write = psel & penable & pwrite & pready;

    always_comb
    begin
        unique case (cfg_sel)
            REG_EXPECTED_SOURCE: prdata = src_cfg_reg;
            REG_TRANSFER_NUMBER: prdata = xfer_cfg_reg;
            default:             prdata = '0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            src_cfg_reg  <= '0;
            xfer_cfg_reg <= '0;
        end
        else if (cfg_write)
        begin
            if (cfg_sel == REG_EXPECTED_SOURCE)
            begin
                src_cfg_reg <= pwdata;
            end
            else
            begin
                xfer_cfg_reg <= pwdata;
            end
        end
    end

    trrb_ctrl u_ctrl (
        .clk        (clk),
        .rst_n      (rst_n),
        .item_valid (item_valid),
        .item_stall (item_stall),
        .status     (status),
        .cmd        (cmd)
    );

    trrb_datapath #(
        .WINDOW   (WINDOW),
        .TAG_BITS (TAG_BITS)
    ) u_datapath (
        .clk          (clk),
        .rst_n        (rst_n),
        .item         (item),
        .cfg_source   (src_cfg_reg),
        .cfg_transfer (xfer_cfg_reg),
        .cmd          (cmd),
        .status       (status),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .result       (result)
    );

endmodule

// ===== verif/tb_transfer_receive_reorder_buffer_top.sv =====
`timescale 1ns / 1ps
// testbench for transfer_receive_reorder_buffer_top: directed and random words with an
// in-order delivery scoreboard; depends on trrb_pkg and the block's rtl only

import trrb_pkg::*;

class reorder_scoreboard;
    logic [63:0]  src_reg = '0;
    logic [63:0]  xfer_reg = '0;
    logic [63:0]  next_seq = '0;
    bit           slot_full [WINDOW_DEFAULT];
    logic [63:0]  slot_ver [WINDOW_DEFAULT];
    bit           slot_put [WINDOW_DEFAULT];
    logic [15:0]  slot_tag [WINDOW_DEFAULT];
    bit           hs_done = 1'b0;
    bit           wipe_req = 1'b0;
    bit           wipe_seen = 1'b0;
    result_word_t due_results[$];
    int           errors = 0;
    int           n_live = 0;
    int           longest_drain = 0;
    int           kind_seen [5];

    function void set_reg(cfg_reg_t r, logic [63:0] v);
        if (r == REG_EXPECTED_SOURCE)
            src_reg = v;
        else
            xfer_reg = v;
    endfunction

    function int outstanding();
        return due_results.size();
    endfunction

    function void push(kind_t k, logic [63:0] seq, logic [63:0] ver, logic [15:0] tag);
        result_word_t e;
        e.kind        = k;
        e.out_seq     = seq;
        e.out_version = ver;
        e.out_tag     = tag;
        e.last        = 1'b0;
        due_results.insert(due_results.size(), e);
        kind_seen[int'(k)]++;
    endfunction

    function void deliver_in_order();
        int    cnt;
        int    idx;
        bit    any;
        kind_t k;
        if (!hs_done)
            return;
        if (wipe_req && !wipe_seen)
        begin
            push(KIND_WIPE_REQ, '0, '0, '0);
            return;
        end
        any = 1'b0;
        foreach (slot_full[i])
            if (slot_full[i])
                any = 1'b1;
        if (!any)
        begin
            push(KIND_WIPED, '0, '0, '0);
            return;
        end
        cnt = 0;
        while (cnt < MAX_DRAIN)
        begin
            idx = int'(next_seq % 64'(WINDOW_DEFAULT));
            if (!slot_full[idx])
                break;
            if (slot_put[idx])
            begin
                k = KIND_PUT;
                push(k, next_seq, slot_ver[idx], slot_tag[idx]);
            end
            else
            begin
                k = KIND_DELETE;
                push(k, next_seq, '0, slot_tag[idx]);
            end
            slot_full[idx] = 1'b0;
            next_seq++;
            cnt++;
        end
    endfunction

    function void note_item(item_word_t w);
        int n_before;
        int idx;
        n_before = due_results.size();
        if (w.xfer_id != xfer_reg)
            return;
        if (w.cmd == CMD_DATA)
        begin
            if (w.src_id != src_reg)
                return;
            n_live++;
            if (w.seq_no < next_seq)
                push(KIND_REACK, w.seq_no, '0, '0);
            else
            begin
                if (w.seq_no - next_seq >= 64'(WINDOW_DEFAULT))
                    return;
                idx = int'(w.seq_no % 64'(WINDOW_DEFAULT));
                if (slot_full[idx])
                    return;
                slot_full[idx] = 1'b1;
                slot_ver[idx]  = w.obj_version;
                slot_put[idx]  = w.put_flag;
                slot_tag[idx]  = w.payload_tag;
                deliver_in_order();
            end
        end
        else if (w.cmd == CMD_HS_ACK)
        begin
            if (w.src_id != src_reg)
                return;
            n_live++;
            if (!hs_done)
            begin
                hs_done  = 1'b1;
                wipe_req = w.wipe_flag;
            end
            deliver_in_order();
        end
        else if (w.cmd == CMD_WIPE_DONE)
        begin
            n_live++;
            wipe_seen = 1'b1;
            deliver_in_order();
        end
        else
            return;
        if (due_results.size() > n_before)
        begin
            due_results[due_results.size() - 1].last = 1'b1;
            if (due_results.size() - n_before > longest_drain)
                longest_drain = due_results.size() - n_before;
        end
    endfunction

    function void report(string what, logic [63:0] exp_v, logic [63:0] act_v);
        errors++;
        $display("%0t: %s mismatch, expected %0h, actual %0h", $time, what, exp_v, act_v);
    endfunction

    function void check_result(result_word_t r);
        result_word_t e;
        if (due_results.size() == 0)
        begin
            report("unexpected result word, kind", '0, 64'(r.kind));
            return;
        end
        e = due_results[0];
        due_results.delete(0);
        if (r.kind !== e.kind)
            report("kind", 64'(e.kind), 64'(r.kind));
        if (r.out_seq !== e.out_seq)
            report("out_seq", e.out_seq, r.out_seq);
        if (r.out_version !== e.out_version)
            report("out_version", e.out_version, r.out_version);
        if (r.out_tag !== e.out_tag)
            report("out_tag", 64'(e.out_tag), 64'(r.out_tag));
        if (r.last !== e.last)
            report("last", 64'(e.last), 64'(r.last));
    endfunction
endclass

module tb_transfer_receive_reorder_buffer_top;
    import trrb_pkg::*;

    localparam logic [1:0] CMD_UNUSED   = 2'd3;
    localparam int         SETTLE       = 16;
    localparam int         IDLE_LIMIT   = 2000;
    localparam int         PHASE_ITEMS  = 18;

    logic                    clk;
    logic                    rst_n;
    logic                    item_valid;
    logic                    item_stall;
    item_word_t              item;
    logic                    result_valid;
    logic                    result_stall = 1'b0;
    result_word_t            result;
    logic                    psel;
    logic                    penable;
    logic                    pwrite;
    logic [CFG_ADDR_W-1:0]   paddr;
    logic [CFG_DATA_W-1:0]   pwdata;
    logic [CFG_DATA_W-1:0]   prdata;
    logic                    pready;

    bit                      no_idle = 1'b0;
    int                      idle_cycles = 0;
    reorder_scoreboard       sb;

    transfer_receive_reorder_buffer_top u_top (.*);

    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    always @(posedge clk)
    begin
        if (rst_n && result_valid && !result_stall)
            sb.check_result(result);
        result_stall <= !no_idle && ($urandom_range(0, 99) < 11);
    end

    always @(posedge clk)
    begin
        if ((item_valid && !item_stall) || (result_valid && !result_stall) || psel)
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= IDLE_LIMIT)
        begin
            $display("RESULT: ERROR");
            $finish;
        end
    end

    function automatic item_word_t good_word(cmd_t c, logic [63:0] seq);
        item_word_t w;
        w.cmd         = c;
        w.src_id      = sb.src_reg;
        w.xfer_id     = sb.xfer_reg;
        w.seq_no      = seq;
        w.put_flag    = 1'($urandom_range(0, 1));
        w.obj_version = {$urandom, $urandom};
        w.payload_tag = 16'($urandom);
        w.wipe_flag   = 1'($urandom_range(0, 1));
        return w;
    endfunction

    task automatic send_word(item_word_t w);
        while (!no_idle && $urandom_range(0, 99) < 11)
        begin
            item_valid <= 1'b0;
            @(posedge clk);
        end
        item_valid <= 1'b1;
        item       <= w;
        @(posedge clk);
        while (item_stall)
            @(posedge clk);
        sb.note_item(w);
    endtask

    task automatic write_reg(cfg_reg_t r, logic [63:0] v);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {r, 3'b000};
        pwdata  <= v;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready)
            @(posedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        sb.set_reg(r, v);
    endtask

    task automatic wait_quiet();
        item_valid <= 1'b0;
        while (sb.outstanding() != 0)
            @(posedge clk);
        repeat (SETTLE) @(posedge clk);
    endtask

    // shuffled run of consecutive sequence numbers from the window head
    task automatic send_burst(int k, bit head_last);
        logic [63:0] base;
        int          order[$];
        int          t;
        int          tmp;
        base = sb.next_seq;
        for (int i = 0; i < k; i++)
            order.insert(order.size(), i);
        for (int j = k - 1; j > 0; j--)
        begin
            t        = $urandom_range(0, j);
            tmp      = order[j];
            order[j] = order[t];
            order[t] = tmp;
        end
        if (head_last)
            for (int j = 0; j < k; j++)
                if (order[j] == 0)
                begin
                    order[j]     = order[k - 1];
                    order[k - 1] = 0;
                end
        foreach (order[i])
            send_word(good_word(CMD_DATA, base + 64'(order[i])));
    endtask

    task automatic random_phase(bit with_full);
        int          start;
        int          pick;
        int          span;
        logic [63:0] s;
        item_word_t  w;
        start = sb.n_live;
        if (with_full)
            send_burst(WINDOW_DEFAULT, 1'b1);
        while (sb.n_live - start < PHASE_ITEMS)
        begin
            pick = $urandom_range(0, 99);
            if (pick < 60)
                send_burst($urandom_range(1, 6), 1'b0);
            else if (pick < 67 && sb.next_seq != 0)
            begin
                span = (sb.next_seq > 8) ? 8 : int'(sb.next_seq);
                send_word(good_word(CMD_DATA, sb.next_seq - 64'($urandom_range(1, span))));
            end
            else if (pick < 74)
            begin
                // stored ahead of a gap, then repeated
                s = sb.next_seq + 64'($urandom_range(1, WINDOW_DEFAULT - 1));
                w = good_word(CMD_DATA, s);
                send_word(w);
                send_word(w);
            end
            else if (pick < 80)
            begin
                if ($urandom_range(0, 1))
                    s = sb.next_seq + 64'(WINDOW_DEFAULT);
                else
                    s = {$urandom, $urandom};
                send_word(good_word(CMD_DATA, s));
            end
            else if (pick < 87)
            begin
                w = good_word($urandom_range(0, 1) ? CMD_DATA : CMD_HS_ACK, {$urandom, $urandom});
                case ($urandom_range(0, 2))
                    0: w.src_id = w.src_id ^ {$urandom, $urandom | 32'd1};
                    1: w.xfer_id = w.xfer_id ^ {$urandom | 32'd1, $urandom};
                    default: w.cmd = CMD_UNUSED;
                endcase
                send_word(w);
            end
            else if (pick < 94)
                send_word(good_word(CMD_HS_ACK, {$urandom, $urandom}));
            else
                send_word(good_word(CMD_WIPE_DONE, {$urandom, $urandom}));
        end
    endtask

    initial
    begin
        item_word_t w;
        sb         = new();
        rst_n      = 1'b0;
        item_valid = 1'b0;
        item       = '0;
        psel       = 1'b0;
        penable    = 1'b0;
        pwrite     = 1'b0;
        paddr      = '0;
        pwdata     = '0;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        write_reg(REG_EXPECTED_SOURCE, {$urandom, $urandom});
        write_reg(REG_TRANSFER_NUMBER, {$urandom, $urandom});

        // stored before the handshake, nothing leaves yet
        send_word(good_word(CMD_DATA, 64'd1));
        w = good_word(CMD_DATA, 64'd0);
        w.put_flag    = 1'b1;
        w.obj_version = '1;
        w.payload_tag = '1;
        send_word(w);
        send_word(good_word(CMD_DATA, 64'd1));
        w = good_word(CMD_DATA, 64'd0);
        w.src_id = ~w.src_id;
        send_word(w);
        w = good_word(CMD_DATA, 64'd0);
        w.xfer_id = ~w.xfer_id;
        send_word(w);
        w = good_word(CMD_DATA, 64'd0);
        w.cmd = CMD_UNUSED;
        send_word(w);
        send_word(good_word(CMD_DATA, 64'(WINDOW_DEFAULT)));
        send_word(good_word(CMD_DATA, '1));
        w = good_word(CMD_WIPE_DONE, '0);
        w.xfer_id = ~w.xfer_id;
        send_word(w);

        // handshake asking for a wipe, then the wipe completes
        w = good_word(CMD_HS_ACK, '0);
        w.wipe_flag = 1'b1;
        w.src_id    = ~w.src_id;
        send_word(w);
        w.src_id = sb.src_reg;
        send_word(w);
        w.wipe_flag = 1'b0;
        send_word(w);
        w = good_word(CMD_DATA, 64'd2);
        w.put_flag    = 1'b0;
        w.obj_version = '0;
        w.payload_tag = '0;
        send_word(w);
        send_word(good_word(CMD_WIPE_DONE, '1));

        // stale, empty window and a gap filled later
        send_word(good_word(CMD_DATA, 64'd1));
        send_word(good_word(CMD_DATA, 64'd0));
        send_word(good_word(CMD_HS_ACK, '0));
        send_word(good_word(CMD_WIPE_DONE, '0));
        send_word(good_word(CMD_DATA, 64'd4));
        send_word(good_word(CMD_DATA, 64'd3));

        for (int ph = 1; ph <= 3; ph++)
        begin
            wait_quiet();
            case (ph)
                1:
                begin
                    write_reg(REG_EXPECTED_SOURCE, '1);
                    write_reg(REG_TRANSFER_NUMBER, '0);
                end
                2:
                begin
                    write_reg(REG_EXPECTED_SOURCE, '0);
                    write_reg(REG_TRANSFER_NUMBER, '1);
                end
                default:
                begin
                    write_reg(REG_EXPECTED_SOURCE, {$urandom, $urandom});
                    write_reg(REG_TRANSFER_NUMBER, {$urandom, $urandom});
                end
            endcase
            no_idle <= (ph == 2);
            random_phase(ph == 1);
        end

        wait_quiet();
        $display("covered %0d live words: %0d puts, %0d deletes, %0d re-acks, %0d wipe requests",
                 sb.n_live, sb.kind_seen[KIND_PUT], sb.kind_seen[KIND_DELETE],
                 sb.kind_seen[KIND_REACK], sb.kind_seen[KIND_WIPE_REQ]);
        $display("%0d wiped notices, longest drain %0d words, four id settings incl. all-0/all-1",
                 sb.kind_seen[KIND_WIPED], sb.longest_drain);
        if (sb.errors == 0 && sb.outstanding() == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end
endmodule

// ===== filelist.f =====
hw/rtl/trrb_pkg.sv
hw/rtl/trrb_datapath.sv
hw/rtl/trrb_ctrl.sv
hw/rtl/transfer_receive_reorder_buffer_top.sv
verif/tb_transfer_receive_reorder_buffer_top.sv
